/* rtl/core/per_sensor_min_max_mean_core_assert.svh */
// assertion macros for the per-sensor statistics core
// define ASSERT_OFF to compile them away
`ifndef PER_SENSOR_MIN_MAX_MEAN_CORE_ASSERT_SVH
`define PER_SENSOR_MIN_MAX_MEAN_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property holds at every edge outside reset
`define PSMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a result in the next
`define PSMM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define PSMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSMM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

/* rtl/core/psmm_pkg.sv */
`timescale 1ns / 1ps

package psmm_pkg;

    // fixed field widths of the transaction ports
    localparam int ID_W    = 10;
    localparam int RD_W    = 16;
    localparam int DATE_W  = 16;
    localparam int TIME_W  = 17;
    localparam int CNT_O_W = 20;

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_DIVIDE
    } psmm_state_t;

endpackage

/* rtl/core/psmm_upd.sv */
`timescale 1ns / 1ps

// bit-serial sample update: saturating sum add, saturating count increment,
// and lsb-first compare of the reading against the stored extremes
module psmm_upd #(
    parameter int COUNT_BITS = 20,
    parameter int VALUE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [COUNT_BITS-1:0]            count_in,
    input  logic [VALUE_BITS+COUNT_BITS-1:0] sum_in,
    input  logic [VALUE_BITS-1:0]            reading_in,
    input  logic [VALUE_BITS-1:0]            max_in,
    input  logic [VALUE_BITS-1:0]            min_in,
    output logic                             done,
    output logic [COUNT_BITS-1:0]            count_out,
    output logic [VALUE_BITS+COUNT_BITS-1:0] sum_out,
    output logic                             gt_max,
    output logic                             lt_min
);

    localparam int SUM_W = VALUE_BITS + COUNT_BITS;
    localparam int BC_W  = $clog2(SUM_W);

    logic [SUM_W-1:0]      sum_sh_reg, sum_sh_next;
    logic [SUM_W-1:0]      add_sh_reg, add_sh_next;
    logic                  carry_reg, carry_next;
    logic [COUNT_BITS-1:0] cnt_sh_reg, cnt_sh_next;
    logic                  ccarry_reg, ccarry_next;
    logic [VALUE_BITS-1:0] max_sh_reg, max_sh_next;
    logic [VALUE_BITS-1:0] min_sh_reg, min_sh_next;
    logic                  gt_reg, gt_next;
    logic                  lt_reg, lt_next;
    logic [BC_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic sbit;
    logic cbit;
    logic rbit;

    always_comb
    begin
        sum_sh_next  = sum_sh_reg;
        add_sh_next  = add_sh_reg;
        carry_next   = carry_reg;
        cnt_sh_next  = cnt_sh_reg;
        ccarry_next  = ccarry_reg;
        max_sh_next  = max_sh_reg;
        min_sh_next  = min_sh_reg;
        gt_next      = gt_reg;
        lt_next      = lt_reg;
        bit_cnt_next = bit_cnt_reg;
        run_next     = run_reg;
        done_next    = 1'b0;
        rbit         = add_sh_reg[0];
        sbit         = sum_sh_reg[0] ^ add_sh_reg[0] ^ carry_reg;
        cbit         = cnt_sh_reg[0] ^ ccarry_reg;
        if (start)
        begin
            sum_sh_next  = sum_in;
            add_sh_next  = SUM_W'(reading_in);
            carry_next   = 1'b0;
            cnt_sh_next  = count_in;
            ccarry_next  = 1'b1;
            max_sh_next  = max_in;
            min_sh_next  = min_in;
            gt_next      = 1'b0;
            lt_next      = 1'b0;
            bit_cnt_next = '0;
            run_next     = 1'b1;
        end
        else if (run_reg)
        begin
            // full adder, one bit per cycle
            sum_sh_next = {sbit, sum_sh_reg[SUM_W-1:1]};
            carry_next  = (sum_sh_reg[0] & add_sh_reg[0]) | (carry_reg & sum_sh_reg[0])
                        | (carry_reg & add_sh_reg[0]);
            add_sh_next = {1'b0, add_sh_reg[SUM_W-1:1]};
            // half adder increment while count bits remain
            if (bit_cnt_reg < BC_W'(COUNT_BITS))
            begin
                cnt_sh_next = {cbit, cnt_sh_reg[COUNT_BITS-1:1]};
                ccarry_next = cnt_sh_reg[0] & ccarry_reg;
            end
            // higher bits override the verdict of lower ones
            if (rbit != max_sh_reg[0])
            begin
                gt_next = rbit;
            end
            if (rbit != min_sh_reg[0])
            begin
                lt_next = min_sh_reg[0];
            end
            max_sh_next  = {1'b0, max_sh_reg[VALUE_BITS-1:1]};
            min_sh_next  = {1'b0, min_sh_reg[VALUE_BITS-1:1]};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (bit_cnt_reg == BC_W'(SUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_sh_reg  <= sum_sh_next;
        add_sh_reg  <= add_sh_next;
        carry_reg   <= carry_next;
        cnt_sh_reg  <= cnt_sh_next;
        ccarry_reg  <= ccarry_next;
        max_sh_reg  <= max_sh_next;
        min_sh_reg  <= min_sh_next;
        gt_reg      <= gt_next;
        lt_reg      <= lt_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    // carry out of the top bit means saturation
    assign done      = done_reg;
    assign sum_out   = carry_reg ? '1 : sum_sh_reg;
    assign count_out = ccarry_reg ? '1 : cnt_sh_reg;
    assign gt_max    = gt_reg;
    assign lt_min    = lt_reg;

endmodule

/* rtl/core/psmm_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, msb first
module psmm_div #(
    parameter int DIVIDEND_W = 36,
    parameter int DIVISOR_W  = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int BC_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [BC_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        bit_cnt_next = bit_cnt_reg;
        run_next     = run_reg;
        done_next    = 1'b0;
        trial        = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff         = trial - {1'b0, dvs_reg};
        fits         = (trial >= {1'b0, dvs_reg});
        if (start)
        begin
            quo_next     = dividend;
            rem_next     = '0;
            dvs_next     = divisor;
            bit_cnt_next = '0;
            run_next     = 1'b1;
        end
        else if (run_reg)
        begin
            // partial remainder stays below the divisor
            rem_next     = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next     = {quo_reg[DIVIDEND_W-2:0], fits};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (bit_cnt_reg == BC_W'(DIVIDEND_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/per_sensor_min_max_mean_core.sv */
`timescale 1ns / 1ps
// sample transaction: busy through the fetch and the bit-serial sum/count/compare unit,
//   which walks one bit of the sum each cycle
// read transaction: done pulses once the restoring divider (one quotient bit per cycle)
//   finishes; an empty id answers from the fetch state through the registered done
// reset: a clearing pass writes zero counts and sums to every entry, with busy high
// results hold for one cycle under done; the receiver cannot stall
`include "per_sensor_min_max_mean_core_assert.svh"

module per_sensor_min_max_mean_core #(
    parameter int NUM_SENSORS = 1024,
    parameter int COUNT_BITS  = 20,
    parameter int VALUE_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [psmm_pkg::ID_W-1:0]     sensor_id,
    input  logic [psmm_pkg::RD_W-1:0]     reading,
    input  logic [psmm_pkg::DATE_W-1:0]   sample_date,
    input  logic [psmm_pkg::TIME_W-1:0]   sample_time,
    output logic                          done,
    output logic [psmm_pkg::ID_W-1:0]     out_id,
    output logic [psmm_pkg::RD_W-1:0]     max_reading,
    output logic [psmm_pkg::DATE_W-1:0]   max_day,
    output logic [psmm_pkg::TIME_W-1:0]   max_tod,
    output logic [psmm_pkg::RD_W-1:0]     min_reading,
    output logic [psmm_pkg::DATE_W-1:0]   min_day,
    output logic [psmm_pkg::TIME_W-1:0]   min_tod,
    output logic [psmm_pkg::RD_W-1:0]     mean_reading,
    output logic [psmm_pkg::CNT_O_W-1:0]  sample_count,
    output logic                          empty_res,
    output logic [psmm_pkg::TIME_W-1:0]   latest_time,
    output logic [psmm_pkg::ID_W-1:0]     highest_id
);

    import psmm_pkg::*;

    localparam int SUM_W   = VALUE_BITS + COUNT_BITS;
    localparam int IDX_W   = $clog2(NUM_SENSORS);
    localparam int EXT_W   = VALUE_BITS + DATE_W + TIME_W;
    localparam int LIM_W   = 17;
    localparam logic [LIM_W-1:0] NUM_LIM = LIM_W'(NUM_SENSORS);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(NUM_SENSORS - 1);

    // extreme entry layout: value, date, time from msb down
    localparam int T_LO = 0;
    localparam int D_LO = TIME_W;
    localparam int V_LO = TIME_W + DATE_W;

    // storage: count and sum are cleared after reset, extremes are not
    logic [COUNT_BITS-1:0] cnt_mem [NUM_SENSORS];
    logic [SUM_W-1:0]      sum_mem [NUM_SENSORS];
    logic [EXT_W-1:0]      max_mem [NUM_SENSORS];
    logic [EXT_W-1:0]      min_mem [NUM_SENSORS];

    psmm_state_t state_reg, state_next;

    logic [IDX_W-1:0]      clr_addr_reg;
    logic [ID_W-1:0]       top_id_reg;
    logic [TIME_W-1:0]     last_time_reg;
    logic                  done_reg;

    // captured transaction
    logic                  act_reg;
    logic [ID_W-1:0]       id_reg;
    logic                  in_range_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [DATE_W-1:0]     date_reg;
    logic [TIME_W-1:0]     time_reg;

    // registered memory read data
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [SUM_W-1:0]      sum_rd_reg;
    logic [EXT_W-1:0]      max_rd_reg;
    logic [EXT_W-1:0]      min_rd_reg;

    // result registers
    logic [ID_W-1:0]       out_id_reg;
    logic [RD_W-1:0]       max_reading_reg;
    logic [DATE_W-1:0]     max_day_reg;
    logic [TIME_W-1:0]     max_tod_reg;
    logic [RD_W-1:0]       min_reading_reg;
    logic [DATE_W-1:0]     min_day_reg;
    logic [TIME_W-1:0]     min_tod_reg;
    logic [RD_W-1:0]       mean_reading_reg;
    logic [CNT_O_W-1:0]    sample_count_reg;
    logic                  empty_res_reg;
    logic [TIME_W-1:0]     latest_time_reg;
    logic [ID_W-1:0]       highest_id_reg;

    logic                  accept;
    logic                  in_range;
    logic                  first_sample;
    logic                  upd_start;
    logic                  div_start;
    logic                  wr_upd;
    logic                  rep_empty;
    logic                  rep_full;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [COUNT_BITS-1:0] mem_wcnt;
    logic [SUM_W-1:0]      mem_wsum;
    logic [EXT_W-1:0]      new_entry;
    logic [EXT_W-1:0]      max_wr;
    logic [EXT_W-1:0]      min_wr;

    logic                  upd_done;
    logic [COUNT_BITS-1:0] upd_count;
    logic [SUM_W-1:0]      upd_sum;
    logic                  upd_gt;
    logic                  upd_lt;

    logic                  div_done;
    logic [SUM_W-1:0]      div_quo;
    logic [VALUE_BITS-1:0] mean_clamped;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign in_range     = (LIM_W'(sensor_id) < NUM_LIM);
    assign first_sample = (cnt_rd_reg == '0);

    // ---------------------------------------------------------------
    // control sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        upd_start  = 1'b0;
        div_start  = 1'b0;
        wr_upd     = 1'b0;
        rep_empty  = 1'b0;
        rep_full   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_IX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // a sample for an id outside the table is dropped here
                if (accept && (action == ACT_READ || in_range))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (act_reg == ACT_SAMPLE)
                begin
                    upd_start  = 1'b1;
                    state_next = ST_UPDATE;
                end
                else if (!in_range_reg || first_sample)
                begin
                    rep_empty  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_UPDATE:
            begin
                if (upd_done)
                begin
                    wr_upd     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    rep_full   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // clearing pass address and global trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            top_id_reg    <= '0;
            last_time_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= rep_empty || rep_full;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (wr_upd)
            begin
                last_time_reg <= time_reg;
                if (id_reg > top_id_reg)
                begin
                    top_id_reg <= id_reg;
                end
            end
        end
    end

    // capture the transaction fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= action;
            id_reg       <= sensor_id;
            in_range_reg <= in_range;
            val_reg      <= VALUE_BITS'(reading);
            date_reg     <= sample_date;
            time_reg     <= sample_time;
        end
    end

    // ---------------------------------------------------------------
    // statistics store
    // ---------------------------------------------------------------
    assign new_entry = {val_reg, date_reg, time_reg};
    // first sample seeds both extremes, ties keep the older entry
    assign max_wr    = (first_sample || upd_gt) ? new_entry : max_rd_reg;
    assign min_wr    = (first_sample || upd_lt) ? new_entry : min_rd_reg;

    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR) || wr_upd;
        mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : IDX_W'(id_reg);
        mem_wcnt  = (state_reg == ST_CLEAR) ? '0 : upd_count;
        mem_wsum  = (state_reg == ST_CLEAR) ? '0 : upd_sum;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_waddr] <= mem_wcnt;
            sum_mem[mem_waddr] <= mem_wsum;
        end
        if (wr_upd)
        begin
            max_mem[mem_waddr] <= max_wr;
            min_mem[mem_waddr] <= min_wr;
        end
        // read issued on the accept edge, data ready in the fetch cycle
        if (accept)
        begin
            cnt_rd_reg <= cnt_mem[IDX_W'(sensor_id)];
            sum_rd_reg <= sum_mem[IDX_W'(sensor_id)];
            max_rd_reg <= max_mem[IDX_W'(sensor_id)];
            min_rd_reg <= min_mem[IDX_W'(sensor_id)];
        end
    end

    // ---------------------------------------------------------------
    // serial arithmetic units
    // ---------------------------------------------------------------
    psmm_upd #(
        .COUNT_BITS (COUNT_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_upd (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (upd_start),
        .count_in   (cnt_rd_reg),
        .sum_in     (sum_rd_reg),
        .reading_in (val_reg),
        .max_in     (max_rd_reg[EXT_W-1:V_LO]),
        .min_in     (min_rd_reg[EXT_W-1:V_LO]),
        .done       (upd_done),
        .count_out  (upd_count),
        .sum_out    (upd_sum),
        .gt_max     (upd_gt),
        .lt_min     (upd_lt)
    );

    psmm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend   (sum_rd_reg),
        .divisor    (cnt_rd_reg),
        .done       (div_done),
        .quotient   (div_quo)
    );

    // mean above the value range clamps to its maximum
    assign mean_clamped = (|div_quo[SUM_W-1:VALUE_BITS]) ? '1 : div_quo[VALUE_BITS-1:0];

    // ---------------------------------------------------------------
    // result registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rep_empty || rep_full)
        begin
            out_id_reg      <= id_reg;
            latest_time_reg <= last_time_reg;
            highest_id_reg  <= top_id_reg;
        end
        if (rep_empty)
        begin
            max_reading_reg  <= '0;
            max_day_reg      <= '0;
            max_tod_reg      <= '0;
            min_reading_reg  <= '0;
            min_day_reg      <= '0;
            min_tod_reg      <= '0;
            mean_reading_reg <= '0;
            sample_count_reg <= '0;
            empty_res_reg    <= 1'b1;
        end
        else if (rep_full)
        begin
            max_reading_reg  <= RD_W'(max_rd_reg[EXT_W-1:V_LO]);
            max_day_reg      <= max_rd_reg[V_LO-1:D_LO];
            max_tod_reg      <= max_rd_reg[D_LO-1:T_LO];
            min_reading_reg  <= RD_W'(min_rd_reg[EXT_W-1:V_LO]);
            min_day_reg      <= min_rd_reg[V_LO-1:D_LO];
            min_tod_reg      <= min_rd_reg[D_LO-1:T_LO];
            mean_reading_reg <= RD_W'(mean_clamped);
            sample_count_reg <= CNT_O_W'(cnt_rd_reg);
            empty_res_reg    <= 1'b0;
        end
    end

    assign done         = done_reg;
    assign out_id       = out_id_reg;
    assign max_reading  = max_reading_reg;
    assign max_day      = max_day_reg;
    assign max_tod      = max_tod_reg;
    assign min_reading  = min_reading_reg;
    assign min_day      = min_day_reg;
    assign min_tod      = min_tod_reg;
    assign mean_reading = mean_reading_reg;
    assign sample_count = sample_count_reg;
    assign empty_res    = empty_res_reg;
    assign latest_time  = latest_time_reg;
    assign highest_id   = highest_id_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a result never lasts longer than one cycle
    `PSMM_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe held")
    // an accepted read always starts work
    `PSMM_ASSERT_NEXT(a_read_busy, clk, rst_n, start && !busy && action == ACT_READ, busy,
        "read transaction not taken")
    // an empty answer carries no statistics
    `PSMM_ASSERT(a_empty_zero, clk, rst_n,
        done && empty_res |-> sample_count == '0 && mean_reading == '0,
        "empty result carries data")
    // a filled answer has samples and ordered extremes
    `PSMM_ASSERT(a_full_order, clk, rst_n,
        done && !empty_res |-> sample_count != '0 && min_reading <= max_reading,
        "extremes out of order")
    // the update unit finishes only while the sequencer waits for it
    `PSMM_ASSERT(a_upd_state, clk, rst_n, upd_done |-> state_reg == ST_UPDATE,
        "stray update completion")

endmodule

/* verif/per_sensor_min_max_mean_core_test.sv */
`timescale 1ns / 1ps

module per_sensor_min_max_mean_core_test;

    import psmm_pkg::*;

    // widths and limits of the statistics store, matching the core defaults
    localparam int NUM_SENSORS = 1024;
    localparam int COUNT_BITS  = 20;
    localparam int VALUE_BITS  = 16;
    localparam int SUM_W       = VALUE_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0]      SUM_MAX = '1;
    localparam logic [SUM_W-1:0]      VAL_MAX = {{COUNT_BITS{1'b0}}, {VALUE_BITS{1'b1}}};

    // random part of the stimulus and the pool of frequently hit sensors
    localparam int RANDOM_CMDS = 880;
    localparam int HOT_IDS     = 12;

    // one transaction offered to the core, with its pacing attached
    typedef struct {
        logic              action;
        logic [ID_W-1:0]   id;
        logic [RD_W-1:0]   reading;
        logic [DATE_W-1:0] day;
        logic [TIME_W-1:0] tod;
        int unsigned       gap_pct;      // chance per cycle of holding the transaction back
        bit                drain_first;  // wait until all summaries are back
    } sensor_cmd_t;

    // one summary as the core should report it
    typedef struct {
        logic [ID_W-1:0]    id;
        logic [RD_W-1:0]    max_rd;
        logic [DATE_W-1:0]  max_day;
        logic [TIME_W-1:0]  max_tod;
        logic [RD_W-1:0]    min_rd;
        logic [DATE_W-1:0]  min_day;
        logic [TIME_W-1:0]  min_tod;
        logic [RD_W-1:0]    mean;
        logic [CNT_O_W-1:0] tally;
        logic               is_empty;
        logic [TIME_W-1:0]  latest;
        logic [ID_W-1:0]    highest;
    } sensor_summary_t;

    // an extreme reading and when it was first seen
    typedef struct packed {
        logic [RD_W-1:0]   value;
        logic [DATE_W-1:0] day;
        logic [TIME_W-1:0] tod;
    } extreme_t;

    // clock, reset and core ports; every input starts at a known value
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                action      = ACT_SAMPLE;
    logic [ID_W-1:0]     sensor_id   = '0;
    logic [RD_W-1:0]     reading     = '0;
    logic [DATE_W-1:0]   sample_date = '0;
    logic [TIME_W-1:0]   sample_time = '0;
    logic                busy;
    logic                done;
    logic [ID_W-1:0]     out_id;
    logic [RD_W-1:0]     max_reading;
    logic [DATE_W-1:0]   max_day;
    logic [TIME_W-1:0]   max_tod;
    logic [RD_W-1:0]     min_reading;
    logic [DATE_W-1:0]   min_day;
    logic [TIME_W-1:0]   min_tod;
    logic [RD_W-1:0]     mean_reading;
    logic [CNT_O_W-1:0]  sample_count;
    logic                empty_res;
    logic [TIME_W-1:0]   latest_time;
    logic [ID_W-1:0]     highest_id;

    // the testbench's own copy of the per-sensor statistics
    logic [COUNT_BITS-1:0] sample_tally [NUM_SENSORS];
    logic [SUM_W-1:0]      reading_total [NUM_SENSORS];
    extreme_t              peak_rec [NUM_SENSORS];
    extreme_t              trough_rec [NUM_SENSORS];
    logic [ID_W-1:0]       top_seen_id = '0;
    logic [TIME_W-1:0]     last_tod    = '0;

    sensor_cmd_t     sensor_cmds[$];        // transactions not yet offered
    sensor_cmd_t     offered_cmd;           // transaction on the input ports
    sensor_summary_t pending_summaries[$];  // summaries owed by the core, oldest first
    int unsigned     fault_count = 0;

    per_sensor_min_max_mean_core #(
        .NUM_SENSORS (NUM_SENSORS),
        .COUNT_BITS  (COUNT_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .sensor_id    (sensor_id),
        .reading      (reading),
        .sample_date  (sample_date),
        .sample_time  (sample_time),
        .done         (done),
        .out_id       (out_id),
        .max_reading  (max_reading),
        .max_day      (max_day),
        .max_tod      (max_tod),
        .min_reading  (min_reading),
        .min_day      (min_day),
        .min_tod      (min_tod),
        .mean_reading (mean_reading),
        .sample_count (sample_count),
        .empty_res    (empty_res),
        .latest_time  (latest_time),
        .highest_id   (highest_id)
    );

    always #2 clk = ~clk;

    // count a failure; only the first ten get a printed line
    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
            note_fault($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endfunction

    // apply one accepted transaction to the statistics copy;
    // a read owes exactly one summary, a sample owes none
    function automatic void track_sensor_stats(sensor_cmd_t cmd);
        sensor_summary_t  s;
        logic [SUM_W-1:0] quotient;
        int unsigned      ix;
        ix = cmd.id;
        if (cmd.action == ACT_SAMPLE) begin
            // ids past the table are dropped; a 10-bit id always fits here
            if (ix < NUM_SENSORS) begin
                if (sample_tally[ix] == '0) begin
                    // first sample sets both extremes
                    peak_rec[ix]   = '{cmd.reading, cmd.day, cmd.tod};
                    trough_rec[ix] = peak_rec[ix];
                end
                else begin
                    // only a strict improvement moves an extreme, ties keep the first
                    if (cmd.reading > peak_rec[ix].value)
                        peak_rec[ix] = '{cmd.reading, cmd.day, cmd.tod};
                    if (cmd.reading < trough_rec[ix].value)
                        trough_rec[ix] = '{cmd.reading, cmd.day, cmd.tod};
                end
                // count and sum both saturate
                if (sample_tally[ix] != CNT_MAX)
                    sample_tally[ix]++;
                if (SUM_MAX - reading_total[ix] < cmd.reading)
                    reading_total[ix] = SUM_MAX;
                else
                    reading_total[ix] += cmd.reading;
                if (cmd.id > top_seen_id)
                    top_seen_id = cmd.id;
                last_tod = cmd.tod;
            end
        end
        else begin
            s = '{default: '0};
            s.id      = cmd.id;
            s.latest  = last_tod;
            s.highest = top_seen_id;
            if (ix >= NUM_SENSORS || sample_tally[ix] == '0) begin
                // empty id reports zeros apart from id, latest time and highest id
                s.is_empty = 1'b1;
            end
            else begin
                quotient = reading_total[ix] / sample_tally[ix];
                if (quotient > VAL_MAX)
                    quotient = VAL_MAX;
                s.max_rd  = peak_rec[ix].value;
                s.max_day = peak_rec[ix].day;
                s.max_tod = peak_rec[ix].tod;
                s.min_rd  = trough_rec[ix].value;
                s.min_day = trough_rec[ix].day;
                s.min_tod = trough_rec[ix].tod;
                s.mean    = quotient[RD_W-1:0];
                s.tally   = sample_tally[ix];
            end
            pending_summaries.insert(pending_summaries.size(), s);
        end
    endfunction

    function automatic void queue_cmd(logic act, logic [ID_W-1:0] id, logic [RD_W-1:0] rd,
                                      logic [DATE_W-1:0] day, logic [TIME_W-1:0] tod);
        sensor_cmd_t c;
        c.action      = act;
        c.id          = id;
        c.reading     = rd;
        c.day         = day;
        c.tod         = tod;
        c.gap_pct     = 0;
        c.drain_first = 1'b0;
        sensor_cmds.insert(sensor_cmds.size(), c);
    endfunction

    // driver: a transaction moves on the edge where start is high and busy is low;
    // start stays up across back-to-back transactions and drops only on a gap
    always @(posedge clk) begin : drive_proc
        logic held;
        if (rst_n) begin
            held = start && busy;
            if (start && !busy)
                track_sensor_stats(offered_cmd);
            if (!held) begin
                if (sensor_cmds.size() > 0
                    && $urandom_range(99) >= sensor_cmds[0].gap_pct
                    && !(sensor_cmds[0].drain_first && pending_summaries.size() > 0)) begin
                    offered_cmd = sensor_cmds.pop_front();
                    start       <= 1'b1;
                    action      <= offered_cmd.action;
                    sensor_id   <= offered_cmd.id;
                    reading     <= offered_cmd.reading;
                    sample_date <= offered_cmd.day;
                    sample_time <= offered_cmd.tod;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each done strobe is one summary, checked against the oldest owed
    always @(posedge clk) begin : check_proc
        sensor_summary_t want;
        if (rst_n && done) begin
            if (pending_summaries.size() == 0) begin
                note_fault($sformatf("summary for id %0d with no read outstanding", out_id));
            end
            else begin
                want = pending_summaries.pop_front();
                check_field("out_id",       want.id,       out_id);
                check_field("max_reading",  want.max_rd,   max_reading);
                check_field("max_day",      want.max_day,  max_day);
                check_field("max_tod",      want.max_tod,  max_tod);
                check_field("min_reading",  want.min_rd,   min_reading);
                check_field("min_day",      want.min_day,  min_day);
                check_field("min_tod",      want.min_tod,  min_tod);
                check_field("mean_reading", want.mean,     mean_reading);
                check_field("sample_count", want.tally,    sample_count);
                check_field("empty_res",    want.is_empty, empty_res);
                check_field("latest_time",  want.latest,   latest_time);
                check_field("highest_id",   want.highest,  highest_id);
            end
        end
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus_proc
        logic [ID_W-1:0] hot_ids [HOT_IDS];
        logic [ID_W-1:0] id;
        logic [RD_W-1:0] rd;
        int unsigned     n;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            sample_tally[i]  = '0;
            reading_total[i] = '0;
            peak_rec[i]      = '0;
            trough_rec[i]    = '0;
        end

        // directed: empty reads before any sample
        queue_cmd(ACT_READ,   10'd0,    16'hFFFF, 16'hFFFF, 17'd86399);
        queue_cmd(ACT_READ,   10'd1023, 16'h0,    16'h0,    17'd0);
        // field extremes on the lowest and highest id
        queue_cmd(ACT_SAMPLE, 10'd0,    16'h0000, 16'h0000, 17'd0);
        queue_cmd(ACT_SAMPLE, 10'd1023, 16'hFFFF, 16'hFFFF, 17'd86399);
        // tie on the maximum keeps the first date and time
        queue_cmd(ACT_SAMPLE, 10'd1023, 16'hFFFF, 16'd1,    17'd1);
        // new minimum, then a tie on it
        queue_cmd(ACT_SAMPLE, 10'd1023, 16'h8000, 16'd2,    17'd2);
        queue_cmd(ACT_SAMPLE, 10'd1023, 16'h8000, 16'd3,    17'd3);
        queue_cmd(ACT_READ,   10'd1023, 16'h1234, 16'h5678, 17'd65536);
        // tie on both extremes of id 0, then a new maximum
        queue_cmd(ACT_SAMPLE, 10'd0,    16'h0000, 16'd5,    17'd5);
        queue_cmd(ACT_SAMPLE, 10'd0,    16'hFFFF, 16'hAAAA, 17'd43690);
        queue_cmd(ACT_READ,   10'd0,    16'h0,    16'h0,    17'd0);
        // single sample: minimum equals maximum
        queue_cmd(ACT_SAMPLE, 10'd5,    16'h5555, 16'h5555, 17'd70000);
        queue_cmd(ACT_READ,   10'd5,    16'h0,    16'h0,    17'd0);
        // empty id after samples still reports highest id and latest time
        queue_cmd(ACT_READ,   10'd512,  16'h0,    16'h0,    17'd0);
        // mean truncates: (1 + 2) / 2
        queue_cmd(ACT_SAMPLE, 10'd2,    16'd1,    16'd10,   17'd100);
        queue_cmd(ACT_SAMPLE, 10'd2,    16'd2,    16'd11,   17'd101);
        queue_cmd(ACT_READ,   10'd2,    16'h0,    16'h0,    17'd0);
        // a sample to a lower id leaves the highest id alone
        queue_cmd(ACT_SAMPLE, 10'd341,  16'h00FF, 16'h0F0F, 17'd12345);
        queue_cmd(ACT_READ,   10'd341,  16'h0,    16'h0,    17'd0);
        // saturation of count and sum needs about a million samples on one id,
        // far past this run; the model above still carries it

        // random: mostly samples and reads on a few hot ids so the records grow,
        // the rest scattered across the whole id range
        hot_ids[0] = 10'd0;
        hot_ids[1] = 10'd1023;
        for (int i = 2; i < HOT_IDS; i++)
            hot_ids[i] = ID_W'($urandom_range(1023));
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            if ($urandom_range(99) < 85)
                id = hot_ids[$urandom_range(HOT_IDS - 1)];
            else
                id = ID_W'($urandom_range(1023));
            case ($urandom_range(9))
                0:       rd = '0;
                1:       rd = '1;
                2, 3:    rd = RD_W'($urandom_range(3));
                default: rd = RD_W'($urandom);
            endcase
            queue_cmd(($urandom_range(99) < 40) ? ACT_READ : ACT_SAMPLE, id, rd,
                      DATE_W'($urandom_range(65535)), TIME_W'($urandom_range(86399)));
        end

        // pacing: light gaps, then heavy gaps, then none; the sender also
        // drains all owed summaries at each phase change and now and then
        n = sensor_cmds.size();
        for (int i = 0; i < n; i++) begin
            sensor_cmds[i].gap_pct     = (i < n / 3) ? 25 : ((i < 2 * n / 3) ? 67 : 0);
            sensor_cmds[i].drain_first = (i == n / 3) || (i == 2 * n / 3)
                                         || ($urandom_range(99) == 0);
        end

        // reset once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait until every transaction is taken and every summary is back
        while (sensor_cmds.size() != 0 || start || pending_summaries.size() != 0)
            @(posedge clk);
        // trailing sample work may still be in the core
        repeat (100) @(posedge clk);

        if (pending_summaries.size() != 0)
            note_fault($sformatf("%0d summaries never arrived", pending_summaries.size()));
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/psmm_pkg.sv
rtl/core/psmm_upd.sv
rtl/core/psmm_div.sv
rtl/core/per_sensor_min_max_mean_core.sv
verif/per_sensor_min_max_mean_core_test.sv
